### src/brsf_pkg.sv
// Shared constants, types and helpers for the breath-reading serial framer.
`default_nettype none
package brsf_pkg;

  // Build-time defaults for the top-level parameters
  localparam int unsigned BurstSamplesDef = 32;
  localparam int unsigned ScaleShiftDef   = 6;

  // Field widths
  localparam int unsigned SampleW  = 10;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ReadingW = 9;
  localparam int unsigned CfgW     = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned SumW     = 16;

  // Stream data packing (padded to whole bytes)
  localparam int unsigned InDataW  = 24;  // sample, rx_byte
  localparam int unsigned OutDataW = 24;  // tx_byte, reading

  // Command queue depth between front and back
  localparam int unsigned QueueDepth = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegOffset    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLimit     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegThreshold = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] OffsetRst    = 10'd120;
  localparam logic [CfgW-1:0] LimitRst     = 10'd300;
  localparam logic [CfgW-1:0] ThresholdRst = 10'd20;

  // Largest reading carried on the output
  localparam logic [ReadingW-1:0] ReadingMax = 9'd511;

  // Serial characters
  localparam logic [ByteW-1:0] ChOpenBrace  = 8'h7B;  // '{'
  localparam logic [ByteW-1:0] ChCloseBrace = 8'h7D;  // '}'
  localparam logic [ByteW-1:0] ChRunStart   = 8'h3E;  // '>'
  localparam logic [ByteW-1:0] ChRunEnd     = 8'h3C;  // '<'
  localparam logic [ByteW-1:0] ChSpace      = 8'h20;
  localparam logic [ByteW-1:0] ChNul        = 8'h00;
  localparam logic [ByteW-1:0] ChZero       = 8'h30;  // '0'

  // Input kind carried on tuser
  localparam logic ModeSample = 1'b0;
  localparam logic ModeSerial = 1'b1;

  // One finished burst that produces output bytes
  typedef struct packed {
    logic [ReadingW-1:0] reading;
    logic                open_run;  // send '>',NUL first
    logic                active;    // 1: digits, space, NUL; 0: '<',NUL
  } brsf_cmd_t;

endpackage
`default_nettype wire

### src/brsf_queue.sv
// Small register FIFO carrying commands from the front to the back.
`default_nettype none
module brsf_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_valid_i,
  output logic                 push_ready_o,
  input  brsf_pkg::brsf_cmd_t  push_cmd_i,
  output logic                 pop_valid_o,
  input  wire                  pop_ready_i,
  output brsf_pkg::brsf_cmd_t  pop_cmd_o
);
  import brsf_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  brsf_cmd_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

### src/brsf_front.sv
// Front end: takes beats, gates on braces, sums bursts and classifies readings.
`default_nettype none
module brsf_front #(
  parameter int unsigned BURST_SAMPLES = brsf_pkg::BurstSamplesDef,
  parameter int unsigned SCALE_SHIFT   = brsf_pkg::ScaleShiftDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            mode_i,
  input  wire  [brsf_pkg::SampleW-1:0]   sample_i,
  input  wire  [brsf_pkg::ByteW-1:0]     rx_byte_i,
  input  wire  [brsf_pkg::CfgW-1:0]      offset_i,
  input  wire  [brsf_pkg::CfgW-1:0]      limit_i,
  input  wire  [brsf_pkg::CfgW-1:0]      threshold_i,
  output logic                           cmd_valid_o,
  input  wire                            cmd_ready_i,
  output brsf_pkg::brsf_cmd_t            cmd_o
);
  import brsf_pkg::*;

  localparam int unsigned CntW = (BURST_SAMPLES > 2) ? $clog2(BURST_SAMPLES) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(BURST_SAMPLES - 1);

  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            en_q, en_d;
  logic            run_q, run_d;
  logic            pend_q, pend_d;
  logic [SumW-1:0] pend_sum_q, pend_sum_d;

  logic            accept, pend_done, need_push;
  logic [SumW-1:0] sum_next, scaled, diff;
  logic [ReadingW-1:0] reading;
  logic            active;

  // Reading of the finished burst
  always_comb begin
    scaled = pend_sum_q >> SCALE_SHIFT;
    diff   = scaled - SumW'(offset_i);
    if (diff == '0 || diff >= SumW'(limit_i)) begin
      reading = '0;
    end else if (diff > SumW'(ReadingMax)) begin
      reading = ReadingMax;
    end else begin
      reading = diff[ReadingW-1:0];
    end
    active    = ({1'b0, reading} > threshold_i);
    need_push = active || run_q;
  end

  assign cmd_valid_o      = pend_q && need_push;
  assign cmd_o.reading    = reading;
  assign cmd_o.open_run   = active && !run_q;
  assign cmd_o.active     = active;
  assign pend_done        = pend_q && (!need_push || cmd_ready_i);
  assign in_ready_o       = !pend_q || pend_done;
  assign accept           = in_valid_i && in_ready_o;
  assign sum_next         = sum_q + SumW'(sample_i);

  always_comb begin
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    en_d       = en_q;
    run_d      = run_q;
    pend_d     = pend_q && !pend_done;
    pend_sum_d = pend_sum_q;
    if (pend_done) begin
      run_d = active;
    end
    if (accept) begin
      if (mode_i == ModeSerial) begin
        if (rx_byte_i == ChOpenBrace) begin
          en_d = 1'b1;
        end else if (rx_byte_i == ChCloseBrace) begin
          en_d = 1'b0;
        end
      end else if (cnt_q != '0 || en_q) begin
        // A started burst always runs to the end
        if (cnt_q == CntLast) begin
          pend_sum_d = sum_next;
          pend_d     = 1'b1;
          sum_d      = '0;
          cnt_d      = '0;
        end else begin
          sum_d = sum_next;
          cnt_d = cnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      en_q   <= 1'b0;
      run_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      en_q   <= en_d;
      run_q  <= run_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sum_q <= pend_sum_d;
  end

endmodule
`default_nettype wire

### src/brsf_back.sv
// Back end: expands a command into serial bytes through an output register.
`default_nettype none
module brsf_back (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cmd_valid_i,
  output logic                            cmd_ready_o,
  input  brsf_pkg::brsf_cmd_t             cmd_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic [brsf_pkg::ByteW-1:0]      tx_byte_o,
  output logic [brsf_pkg::ReadingW-1:0]   reading_o,
  output logic                            last_o
);
  import brsf_pkg::*;

  // Byte sequence positions
  localparam logic [3:0] StStart  = 4'd0;  // '>'
  localparam logic [3:0] StStNul  = 4'd1;
  localparam logic [3:0] StHund   = 4'd2;
  localparam logic [3:0] StTens   = 4'd3;
  localparam logic [3:0] StOnes   = 4'd4;
  localparam logic [3:0] StSpace  = 4'd5;
  localparam logic [3:0] StSpNul  = 4'd6;
  localparam logic [3:0] StEnd    = 4'd7;  // '<'
  localparam logic [3:0] StEndNul = 4'd8;

  logic             busy_q, busy_d;
  logic [3:0]       step_q, step_d;
  logic [3:0]       first_dig_q;
  logic [3:0]       hund_q, tens_q, ones_q;
  logic [ReadingW-1:0] rd_q;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] tx_q, tx_d;
  logic [ReadingW-1:0] out_rd_q;
  logic             last_q, last_d;

  logic             load, can_emit;
  logic [3:0]       c_hund, c_tens, c_ones, c_first, c_start;
  logic [ReadingW-1:0] c_rem;
  logic [14:0]      c_prod;

  // Decimal digits of the incoming reading
  always_comb begin
    if (cmd_i.reading >= 9'd500) begin
      c_hund = 4'd5;
    end else if (cmd_i.reading >= 9'd400) begin
      c_hund = 4'd4;
    end else if (cmd_i.reading >= 9'd300) begin
      c_hund = 4'd3;
    end else if (cmd_i.reading >= 9'd200) begin
      c_hund = 4'd2;
    end else if (cmd_i.reading >= 9'd100) begin
      c_hund = 4'd1;
    end else begin
      c_hund = 4'd0;
    end
    c_rem  = cmd_i.reading - (ReadingW'(c_hund) * 9'd100);
    c_prod = 15'(c_rem[6:0]) * 15'd205;
    c_tens = c_prod[14:11];
    c_ones = 4'(c_rem[6:0] - (7'(c_tens) * 7'd10));
    if (cmd_i.reading >= 9'd100) begin
      c_first = StHund;
    end else if (cmd_i.reading >= 9'd10) begin
      c_first = StTens;
    end else begin
      c_first = StOnes;
    end
    if (cmd_i.open_run) begin
      c_start = StStart;
    end else if (!cmd_i.active) begin
      c_start = StEnd;
    end else begin
      c_start = c_first;
    end
  end

  assign cmd_ready_o = !busy_q;
  assign load        = cmd_valid_i && !busy_q;
  assign can_emit    = !out_valid_q || out_ready_i;

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tx_d        = tx_q;
    last_d      = last_q;
    if (load) begin
      busy_d = 1'b1;
      step_d = c_start;
    end else if (busy_q && can_emit) begin
      out_valid_d = 1'b1;
      last_d      = 1'b0;
      step_d      = step_q + 4'd1;
      case (step_q)
        StStart: tx_d = ChRunStart;
        StStNul: begin
          tx_d   = ChNul;
          step_d = first_dig_q;
        end
        StHund:  tx_d = ChZero + ByteW'(hund_q);
        StTens:  tx_d = ChZero + ByteW'(tens_q);
        StOnes:  tx_d = ChZero + ByteW'(ones_q);
        StSpace: tx_d = ChSpace;
        StSpNul, StEndNul: begin
          tx_d   = ChNul;
          last_d = 1'b1;
          busy_d = 1'b0;
        end
        StEnd:   tx_d = ChRunEnd;
        default: begin
          tx_d   = ChNul;
          last_d = 1'b1;
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= StStart;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_q   <= tx_d;
    last_q <= last_d;
    if (busy_q && can_emit) begin
      out_rd_q <= rd_q;
    end
    if (load) begin
      rd_q        <= cmd_i.reading;
      hund_q      <= c_hund;
      tens_q      <= c_tens;
      ones_q      <= c_ones;
      first_dig_q <= c_first;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_q;
  assign reading_o   = out_rd_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

### src/breath_reading_serial_framer.sv
// Top level of the breath-reading serial framer: config registers, front, queue, back.
//
//  channel   | direction | handshake               | contents
//  ----------+-----------+-------------------------+-----------------------------------
//  s_axis    | in        | s_axis_tvalid/tready    | tuser mode, tdata sample, rx_byte
//  m_axis    | out       | m_axis_tvalid/tready    | tdata tx_byte, reading; tlast last
//  cfg       | in        | cfg_we_i (no wait)      | cfg_index_i, cfg_wdata_i
//
// An input beat is taken every cycle unless the front stalls. The last sample of a burst is
// registered with its sum, scored from that register and queued for the back end, which
// loads a command and then sends one byte per cycle (2 to 7 bytes) while the receiver is
// ready. The rate limit is that single-byte-per-cycle output register: the front stalls
// only when the four-entry command queue is full and another finished burst is waiting.
// Reset clears the burst sum, the enable, the open-run flag and all handshake state.
`default_nettype none
module breath_reading_serial_framer #(
  parameter int unsigned BURST_SAMPLES = brsf_pkg::BurstSamplesDef,
  parameter int unsigned SCALE_SHIFT   = brsf_pkg::ScaleShiftDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [brsf_pkg::InDataW-1:0]     s_axis_tdata,   // [9:0] sample, [17:10] rx_byte
  input  wire                              s_axis_tuser,   // [0] mode
  // Output stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [brsf_pkg::OutDataW-1:0]    m_axis_tdata,   // [7:0] tx_byte, [16:8] reading
  output logic                             m_axis_tlast,
  // Configuration writes
  input  wire                              cfg_we_i,
  input  wire  [brsf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [brsf_pkg::CfgW-1:0]        cfg_wdata_i
);
  import brsf_pkg::*;

  logic [CfgW-1:0]     offset_q, limit_q, threshold_q;
  logic                fq_valid, fq_ready, qb_valid, qb_ready;
  brsf_cmd_t           fq_cmd, qb_cmd;
  logic [ByteW-1:0]    tx_byte;
  logic [ReadingW-1:0] reading;

  // Configuration registers; writes must arrive only while the block is idle; not enforced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= OffsetRst;
      limit_q     <= LimitRst;
      threshold_q <= ThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegOffset:    offset_q    <= cfg_wdata_i;
        RegLimit:     limit_q     <= cfg_wdata_i;
        RegThreshold: threshold_q <= cfg_wdata_i;
        default:      ;  // drop writes to unused indexes
      endcase
    end
  end

  // Front: classify beats, sum bursts, score readings
  brsf_front #(
    .BURST_SAMPLES (BURST_SAMPLES),
    .SCALE_SHIFT   (SCALE_SHIFT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .sample_i    (s_axis_tdata[SampleW-1:0]),
    .rx_byte_i   (s_axis_tdata[SampleW+ByteW-1:SampleW]),
    .offset_i    (offset_q),
    .limit_i     (limit_q),
    .threshold_i (threshold_q),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  // Decouple scoring from byte output
  brsf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_cmd_i   (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_cmd_o    (qb_cmd)
  );

  // Back: expand each command into its byte sequence
  brsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .tx_byte_o   (tx_byte),
    .reading_o   (reading),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OutDataW - ByteW - ReadingW){1'b0}}, reading, tx_byte};

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Stream testbench for the breath-reading serial framer: directed and random beats, self-checked.
module tb_top;
  import brsf_pkg::*;

  localparam int unsigned IdlePct      = 35;  // chance in a hundred that a side idles
  localparam int unsigned SettleCycles = 20;  // quiet cycles before a register write or the end
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned PhaseItems   = 20;  // least input beats in one random phase

  // One output beat as the framer should send it
  typedef struct {
    logic [ByteW-1:0]    tx;
    logic [ReadingW-1:0] rd;
    logic                lst;
  } tx_beat_t;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                s_valid  = 1'b0;
  logic [InDataW-1:0]  s_data   = '0;
  logic                s_user   = ModeSample;
  logic                s_ready;
  logic                m_valid;
  logic                m_ready  = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic                m_last;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = RegOffset;
  logic [CfgW-1:0]     cfg_data = '0;

  // Predictor copy of the configuration and of the framer state
  logic [CfgW-1:0] cfg_offset    = OffsetRst;
  logic [CfgW-1:0] cfg_limit     = LimitRst;
  logic [CfgW-1:0] cfg_threshold = ThresholdRst;
  logic [SumW-1:0] burst_sum     = '0;
  int unsigned     burst_count   = 0;
  bit              readings_on   = 1'b0;
  bit              run_open      = 1'b0;

  tx_beat_t    pending_beats[$];
  bit          quiet         = 1'b0;  // no idling on either side while set
  int unsigned items_sent    = 0;
  int unsigned bursts_scored = 0;
  int unsigned beats_due     = 0;
  int unsigned beats_seen    = 0;
  int unsigned settings_run  = 0;
  int unsigned mismatches    = 0;

  breath_reading_serial_framer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_idx),
    .cfg_wdata_i   (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Score one finished burst and queue the bytes it should produce
  function automatic void score_burst(input logic [SumW-1:0] total);
    logic [SumW-1:0] r;
    tx_beat_t        frame[$];
    int unsigned     v;
    int unsigned     dg[3];
    int              nd;
    r = (total >> ScaleShiftDef) - SumW'(cfg_offset);
    if (r == '0 || r >= SumW'(cfg_limit)) r = '0;
    if (r > SumW'(ReadingMax)) r = SumW'(ReadingMax);
    if (r > SumW'(cfg_threshold)) begin
      if (!run_open) begin
        frame.push_back('{ChRunStart, r[ReadingW-1:0], 1'b0});
        frame.push_back('{ChNul, r[ReadingW-1:0], 1'b0});
        run_open = 1'b1;
      end
      v  = r;
      nd = 0;
      do begin
        dg[nd] = v % 10;
        v      = v / 10;
        nd++;
      end while (v != 0 && nd < 3);
      while (nd > 0) begin
        nd--;
        frame.push_back('{ChZero + ByteW'(dg[nd]), r[ReadingW-1:0], 1'b0});
      end
      frame.push_back('{ChSpace, r[ReadingW-1:0], 1'b0});
      frame.push_back('{ChNul, r[ReadingW-1:0], 1'b0});
    end else if (run_open) begin
      frame.push_back('{ChRunEnd, r[ReadingW-1:0], 1'b0});
      frame.push_back('{ChNul, r[ReadingW-1:0], 1'b0});
      run_open = 1'b0;
    end
    if (frame.size() > 0) frame[frame.size()-1].lst = 1'b1;
    foreach (frame[i]) pending_beats.push_back(frame[i]);
    beats_due += frame.size();
    bursts_scored++;
  endfunction

  // Advance the predictor by one accepted input beat
  function automatic void track_item(input logic mode, input logic [SampleW-1:0] smp,
                                     input logic [ByteW-1:0] rx);
    if (mode == ModeSerial) begin
      if (rx == ChOpenBrace) readings_on = 1'b1;
      else if (rx == ChCloseBrace) readings_on = 1'b0;
      return;
    end
    // drop a sample that would start a burst while readings are off
    if (burst_count == 0 && !readings_on) return;
    burst_sum = burst_sum + SumW'(smp);
    burst_count++;
    if (burst_count >= BurstSamplesDef) begin
      score_burst(burst_sum);
      burst_sum   = '0;
      burst_count = 0;
    end
  endfunction

  // Send one input beat, with a random idle gap first
  task automatic push_item(input logic mode, input logic [SampleW-1:0] smp,
                           input logic [ByteW-1:0] rx);
    if (!quiet) begin
      while ($urandom_range(0, 99) < IdlePct) begin
        s_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= InDataW'({rx, smp});
    do @(posedge clk_i); while (!s_ready);
    items_sent++;
    track_item(mode, smp, rx);
  endtask

  task automatic send_sample(input logic [SampleW-1:0] smp);
    push_item(ModeSample, smp, ByteW'($urandom_range(0, 255)));
  endtask

  task automatic send_serial(input logic [ByteW-1:0] rx);
    push_item(ModeSerial, SampleW'($urandom_range(0, 1023)), rx);
  endtask

  // Hold the input, wait for every queued byte, then let the block settle
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      RegOffset:    cfg_offset    = val;
      RegLimit:     cfg_limit     = val;
      RegThreshold: cfg_threshold = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int unsigned off, input int unsigned lim,
                               input int unsigned thr);
    write_cfg(RegOffset, CfgW'(off));
    write_cfg(RegLimit, CfgW'(lim));
    write_cfg(RegThreshold, CfgW'(thr));
    settings_run++;
  endtask

  // One burst of samples from base to base+spread; mix slips serial bytes in between samples
  task automatic run_burst(input int base, input int unsigned spread, input bit mix);
    int v;
    int k;
    for (int i = 0; i < BurstSamplesDef; i++) begin
      if (mix && $urandom_range(0, 15) == 0) begin
        k = $urandom_range(0, 2);
        if (k == 0) send_serial(ChOpenBrace);
        else if (k == 1) send_serial(ChCloseBrace);
        else send_serial(ByteW'($urandom_range(0, 255)));
      end
      v = base + int'($urandom_range(0, spread));
      if (v > 1023) v = 1023;
      if (v < 0) v = 0;
      send_sample(SampleW'(v));
    end
  endtask

  // Constant sample value that gives the wanted reading under the current offset
  function automatic int sample_for_reading(input int target);
    int v;
    v = 2 * (target + int'(cfg_offset));
    if (v > 1023) v = 1023;
    if (v < 0) v = 0;
    return v;
  endfunction

  task automatic test_enable_gate();
    // samples with readings off and no burst started are dropped
    send_sample(SampleW'(1023));
    send_sample(SampleW'(0));
    // a close brace while off and bytes other than braces change nothing
    send_serial(ChCloseBrace);
    send_serial(8'hFF);
    send_serial(8'h00);
    send_serial(ChRunStart);
    send_sample(SampleW'(512));
    send_serial(ChOpenBrace);
  endtask

  task automatic test_directed_bursts();
    run_burst(340, 0, 0);   // reading 50: open a run
    run_burst(840, 0, 0);   // reading at the upper limit: forced to 0, close the run
    run_burst(280, 0, 0);   // reading equal to the threshold, no run open: silent
    // a close brace in mid-burst must not cut the burst short
    for (int i = 0; i < 10; i++) send_sample(SampleW'(500));
    send_serial(ChCloseBrace);
    for (int i = 0; i < 22; i++) send_sample(SampleW'(500));
    send_sample(SampleW'(500));  // dropped: readings off
    send_serial(ChOpenBrace);
    run_burst(1023, 0, 0);  // full-scale samples exceed the limit: close the run
  endtask

  task automatic test_config_extremes();
    apply_setting(0, 1023, 0);
    run_burst(1023, 0, 0);  // largest reading: seven bytes
    run_burst(2, 0, 0);     // single digit
    run_burst(0, 0, 0);     // zero is never active: close the run
  endtask

  task automatic test_random();
    int unsigned start_items;
    int unsigned k;
    int          j;
    int          base;
    for (int p = 0; p < 2; p++) begin
      if (p == 0) begin
        apply_setting(OffsetRst, LimitRst, ThresholdRst);
      end else begin
        if ($urandom_range(0, 3) == 0) k = $urandom_range(0, 1023);
        else k = $urandom_range(0, 250);
        j = $urandom_range(0, 1023);
        apply_setting(k, j, $urandom_range(0, j));
      end
      // the first phase runs with no idling on either side
      quiet = (p == 0);
      start_items = items_sent;
      while (items_sent - start_items < PhaseItems) begin
        k = $urandom_range(0, 99);
        if (k < 65) begin
          if (!readings_on && $urandom_range(0, 3) != 0) send_serial(ChOpenBrace);
          if ($urandom_range(0, 1) == 0) begin
            j    = $urandom_range(0, 40);
            base = sample_for_reading(int'(cfg_threshold) + j - 20);
          end else begin
            base = $urandom_range(0, 1023);
          end
          if ($urandom_range(0, 1) == 0) run_burst(base, 0, $urandom_range(0, 3) == 0);
          else run_burst(base - 16, $urandom_range(0, 63), $urandom_range(0, 3) == 0);
        end else if (k < 75) begin
          send_serial(ChOpenBrace);
        end else if (k < 83) begin
          send_serial(ChCloseBrace);
        end else if (k < 93) begin
          send_serial(ByteW'($urandom_range(0, 255)));
        end else begin
          send_sample(SampleW'($urandom_range(0, 1023)));
        end
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver side: stall at random except in the quiet stretch
  always @(posedge clk_i) begin
    m_ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
  end

  // Compare every output beat with the oldest expected byte
  always @(posedge clk_i) begin
    tx_beat_t want;
    if (rst_ni && m_valid && m_ready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat tx_byte=%h reading=%0d last=%b", $time,
                 m_data[7:0], m_data[16:8], m_last);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        if (m_data[7:0] !== want.tx) begin
          $display("%0t: tx_byte expected %h actual %h", $time, want.tx, m_data[7:0]);
          mismatches++;
        end
        if (m_data[16:8] !== want.rd) begin
          $display("%0t: reading expected %0d actual %0d", $time, want.rd, m_data[16:8]);
          mismatches++;
        end
        if (m_last !== want.lst) begin
          $display("%0t: last expected %b actual %b", $time, want.lst, m_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_enable_gate();
    test_directed_bursts();
    test_config_extremes();
    test_random();
    s_valid <= 1'b0;
    for (int w = 0; w < DrainLimit && pending_beats.size() != 0; w++) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_beats.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, pending_beats.size());
      mismatches++;
    end
    $display("Covered %0d input beats, %0d scored bursts, %0d register settings",
             items_sent, bursts_scored, settings_run);
    $display("Checked %0d output bytes against %0d predicted, %0d mismatches",
             beats_seen, beats_due, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("%0t: watchdog expired", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule

### breath_reading_serial_framer.f
src/brsf_pkg.sv
src/brsf_queue.sv
src/brsf_front.sv
src/brsf_back.sv
src/breath_reading_serial_framer.sv
tb/sv/tb_top.sv
